FILE: design/jssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jssc_pkg
// Shared types, codes and literal tables for the JSON scalar syntax checker.
// ----------------------------------------------------------------------------
package jssc_pkg;

   // grammar phase of the scanner
   typedef enum logic [3:0] {
      PH_LEAD   = 4'd0,
      PH_LIT    = 4'd1,
      PH_MINUS  = 4'd2,
      PH_ZERO   = 4'd3,
      PH_INT    = 4'd4,
      PH_DOT    = 4'd5,
      PH_FRAC   = 4'd6,
      PH_EXP    = 4'd7,
      PH_EXPSGN = 4'd8,
      PH_EXPDIG = 4'd9,
      PH_TRAIL  = 4'd10
   } phase_type;

   // verdict codes, also used as the sticky error code
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EXPECT  = 2'd1,
      ST_INVALID = 2'd2,
      ST_NOTSING = 2'd3
   } status_type;

   // value kinds
   typedef enum logic [1:0] {
      KIND_NULL  = 2'd0,
      KIND_FALSE = 2'd1,
      KIND_TRUE  = 2'd2,
      KIND_NUM   = 2'd3
   } kind_type;

   // literal selectors
   localparam logic [1:0] LIT_NULL  = 2'd0;
   localparam logic [1:0] LIT_TRUE  = 2'd1;
   localparam logic [1:0] LIT_FALSE = 2'd2;

   localparam int CHAR_W = 8;

   // scanner state carried from one byte to the next
   typedef struct packed {
      phase_type  phase;
      logic [1:0] choice;
      logic [2:0] position;
      status_type error;
      kind_type   kind;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      phase:    PH_LEAD,
      choice:   2'd0,
      position: 3'd0,
      error:    ST_OK,
      kind:     KIND_NULL
   };

   // length of each literal, zero for the unused selector
   function automatic logic [2:0] lit_len(input logic [1:0] choice);
      logic [2:0] len;
      case (choice)
         LIT_NULL:  len = 3'd4;
         LIT_TRUE:  len = 3'd4;
         LIT_FALSE: len = 3'd5;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   // expected letter of a literal at a position
   function automatic logic [CHAR_W-1:0] lit_char(input logic [1:0] choice,
                                                   input logic [2:0] pos);
      logic [CHAR_W-1:0] ch;
      case ({choice, pos})
         {LIT_NULL, 3'd0}:  ch = "n";
         {LIT_NULL, 3'd1}:  ch = "u";
         {LIT_NULL, 3'd2}:  ch = "l";
         {LIT_NULL, 3'd3}:  ch = "l";
         {LIT_TRUE, 3'd0}:  ch = "t";
         {LIT_TRUE, 3'd1}:  ch = "r";
         {LIT_TRUE, 3'd2}:  ch = "u";
         {LIT_TRUE, 3'd3}:  ch = "e";
         {LIT_FALSE, 3'd0}: ch = "f";
         {LIT_FALSE, 3'd1}: ch = "a";
         {LIT_FALSE, 3'd2}: ch = "l";
         {LIT_FALSE, 3'd3}: ch = "s";
         {LIT_FALSE, 3'd4}: ch = "e";
         default:           ch = 8'd0;
      endcase
      return ch;
   endfunction

   // kind reported once a literal is complete
   function automatic kind_type lit_kind(input logic [1:0] choice);
      kind_type k;
      case (choice)
         LIT_TRUE:  k = KIND_TRUE;
         LIT_FALSE: k = KIND_FALSE;
         default:   k = KIND_NULL;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

FILE: design/jssc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jssc_step
// One scanner step: next state and end-of-text verdict for one byte.
// ----------------------------------------------------------------------------
module jssc_step (
   input  wire jssc_pkg::scan_state_type        cur_state,
   input  wire logic [jssc_pkg::CHAR_W-1:0]     char_byte,
   input  wire logic                            end_of_text,
   output jssc_pkg::scan_state_type             nxt_state,
   output jssc_pkg::status_type                 parse_status,
   output jssc_pkg::kind_type                   value_kind
);

   logic       blank;
   logic       digit;
   logic       exp_mark;
   logic [2:0] pos_next;

   // character classes
   assign blank    = (char_byte == " ") || (char_byte == 8'h09) ||
                     (char_byte == 8'h0a) || (char_byte == 8'h0d);
   assign digit    = (char_byte >= "0") && (char_byte <= "9");
   assign exp_mark = (char_byte == "e") || (char_byte == "E");
   assign pos_next = cur_state.position + 3'd1;

   // grammar transitions and verdict
   always_comb begin
      nxt_state    = cur_state;
      parse_status = jssc_pkg::ST_OK;
      value_kind   = jssc_pkg::KIND_NULL;
      if (end_of_text) begin
         nxt_state = jssc_pkg::SCAN_RESET;
         if (cur_state.error != jssc_pkg::ST_OK) begin
            parse_status = cur_state.error;
         end else begin
            case (cur_state.phase)
               jssc_pkg::PH_LEAD: begin
                  parse_status = jssc_pkg::ST_EXPECT;
               end
               jssc_pkg::PH_ZERO, jssc_pkg::PH_INT, jssc_pkg::PH_FRAC,
               jssc_pkg::PH_EXPDIG, jssc_pkg::PH_TRAIL: begin
                  parse_status = jssc_pkg::ST_OK;
                  value_kind   = cur_state.kind;
               end
               default: begin
                  parse_status = jssc_pkg::ST_INVALID;
               end
            endcase
         end
      end else if (cur_state.error == jssc_pkg::ST_OK) begin
         case (cur_state.phase)
            jssc_pkg::PH_LEAD: begin
               if (blank) begin
                  nxt_state.phase = jssc_pkg::PH_LEAD;
               end else if (char_byte == "n" || char_byte == "t" ||
                            char_byte == "f") begin
                  nxt_state.phase    = jssc_pkg::PH_LIT;
                  nxt_state.position = 3'd1;
                  nxt_state.choice   = (char_byte == "n") ? jssc_pkg::LIT_NULL :
                                       (char_byte == "t") ? jssc_pkg::LIT_TRUE :
                                                            jssc_pkg::LIT_FALSE;
               end else begin
                  nxt_state.kind = jssc_pkg::KIND_NUM;
                  if (char_byte == "-") nxt_state.phase = jssc_pkg::PH_MINUS;
                  else if (char_byte == "0") nxt_state.phase = jssc_pkg::PH_ZERO;
                  else if (digit) nxt_state.phase = jssc_pkg::PH_INT;
                  else nxt_state.error = jssc_pkg::ST_INVALID;
               end
            end
            jssc_pkg::PH_LIT: begin
               if (cur_state.position >= jssc_pkg::lit_len(cur_state.choice) ||
                   char_byte != jssc_pkg::lit_char(cur_state.choice,
                                                   cur_state.position)) begin
                  nxt_state.error = jssc_pkg::ST_INVALID;
               end else begin
                  nxt_state.position = pos_next;
                  if (pos_next == jssc_pkg::lit_len(cur_state.choice)) begin
                     nxt_state.kind  = jssc_pkg::lit_kind(cur_state.choice);
                     nxt_state.phase = jssc_pkg::PH_TRAIL;
                  end
               end
            end
            jssc_pkg::PH_MINUS: begin
               if (char_byte == "0") nxt_state.phase = jssc_pkg::PH_ZERO;
               else if (digit) nxt_state.phase = jssc_pkg::PH_INT;
               else nxt_state.error = jssc_pkg::ST_INVALID;
            end
            jssc_pkg::PH_ZERO, jssc_pkg::PH_INT: begin
               if (cur_state.phase == jssc_pkg::PH_INT && digit) begin
                  nxt_state.phase = jssc_pkg::PH_INT;
               end else if (char_byte == ".") begin
                  nxt_state.phase = jssc_pkg::PH_DOT;
               end else if (exp_mark) begin
                  nxt_state.phase = jssc_pkg::PH_EXP;
               end else if (blank) begin
                  nxt_state.phase = jssc_pkg::PH_TRAIL;
               end else begin
                  nxt_state.error = jssc_pkg::ST_NOTSING;
               end
            end
            jssc_pkg::PH_DOT: begin
               if (digit) nxt_state.phase = jssc_pkg::PH_FRAC;
               else nxt_state.error = jssc_pkg::ST_INVALID;
            end
            jssc_pkg::PH_FRAC: begin
               if (digit) nxt_state.phase = jssc_pkg::PH_FRAC;
               else if (exp_mark) nxt_state.phase = jssc_pkg::PH_EXP;
               else if (blank) nxt_state.phase = jssc_pkg::PH_TRAIL;
               else nxt_state.error = jssc_pkg::ST_NOTSING;
            end
            jssc_pkg::PH_EXP: begin
               if (char_byte == "+" || char_byte == "-") begin
                  nxt_state.phase = jssc_pkg::PH_EXPSGN;
               end else if (digit) begin
                  nxt_state.phase = jssc_pkg::PH_EXPDIG;
               end else begin
                  nxt_state.error = jssc_pkg::ST_INVALID;
               end
            end
            jssc_pkg::PH_EXPSGN: begin
               if (digit) nxt_state.phase = jssc_pkg::PH_EXPDIG;
               else nxt_state.error = jssc_pkg::ST_INVALID;
            end
            jssc_pkg::PH_EXPDIG: begin
               if (digit) nxt_state.phase = jssc_pkg::PH_EXPDIG;
               else if (blank) nxt_state.phase = jssc_pkg::PH_TRAIL;
               else nxt_state.error = jssc_pkg::ST_NOTSING;
            end
            jssc_pkg::PH_TRAIL: begin
               if (!blank) nxt_state.error = jssc_pkg::ST_NOTSING;
            end
            default: begin
               nxt_state.error = jssc_pkg::ST_INVALID;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: design/json_scalar_syntax_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_scalar_syntax_checker
// Streaming check that a byte text is one JSON scalar (null, true, false or
// a number), with blanks allowed around it.
// ----------------------------------------------------------------------------
// Send the text one byte per transfer on req_; set req_tlast on one extra
// transfer to close the text (its byte is ignored). That closing transfer
// produces one result on rsp_ in the next cycle: status ok, expect_value,
// invalid_value or root_not_singular, plus the value kind (null after any
// error). The scanner then returns to its start state. One byte is taken
// every cycle: the grammar step is a single combinational pass over the
// scanner state register, and the result register lets a new text start
// while a verdict still waits; req_tready only drops while a held result is
// stalled by rsp_tready.
module json_scalar_syntax_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_byte
   input  wire logic       req_tlast,   // end_of_text
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [1:0] parse_status, [3:2] value_kind
);

   jssc_pkg::scan_state_type state_ff, state_in, step_state;
   jssc_pkg::status_type     step_status, status_ff, status_in;
   jssc_pkg::kind_type       step_kind, kind_ff, kind_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_xfer;

   // grammar step
   jssc_step u_step (
      .cur_state    (state_ff),
      .char_byte    (req_tdata),
      .end_of_text  (req_tlast),
      .nxt_state    (step_state),
      .parse_status (step_status),
      .value_kind   (step_kind)
   );

   // input transfer while the result slot is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   // next state and result register
   always_comb begin
      state_in     = req_xfer ? step_state : state_ff;
      status_in    = status_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_xfer && req_tlast) begin
         status_in    = step_status;
         kind_in      = step_kind;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jssc_pkg::SCAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      kind_ff   <= kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, kind_ff, status_ff};

`ifndef SYNTHESIS
   // closing transfer always yields a result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> rsp_tvalid)
      else $error("no result after end of text");

   // scanner back at start after end of text
   a_restart: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> state_ff == jssc_pkg::SCAN_RESET)
      else $error("scanner not reset after end of text");

   // sticky error survives further bytes
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_tlast && state_ff.error != jssc_pkg::ST_OK
      |=> state_ff.error == $past(state_ff.error))
      else $error("sticky error changed");

   // failed texts report kind null
   a_kind_null: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff != jssc_pkg::ST_OK |-> kind_ff == jssc_pkg::KIND_NULL)
      else $error("non-null kind on failed text");
`endif

endmodule
`default_nettype wire
